/* design/dcfir_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dcfir_pkg;

  localparam int TAP_COUNT    = 51;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int FRAC_BITS    = 20;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  // sum of |coef| is below 2^21, so 40 bits cannot overflow
  localparam int ACC_WIDTH    = 40;
  localparam int QUOT_WIDTH   = ACC_WIDTH - FRAC_BITS;
  localparam int ADDR_WIDTH   = 6;
  localparam int TDATA_WIDTH  = 4 * SAMPLE_WIDTH;

  localparam logic [ADDR_WIDTH-1:0] LAST_TAP = ADDR_WIDTH'(TAP_COUNT - 1);

  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(1) << (FRAC_BITS - 1);
  localparam logic signed [QUOT_WIDTH-1:0] SAT_HI =
    QUOT_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QUOT_WIDTH-1:0] SAT_LO = ~SAT_HI;

  // low-pass taps, value = c / 2^20, tap 0 is the newest sample
  localparam logic signed [COEF_WIDTH-1:0] COEF_TABLE [TAP_COUNT] = '{
    18'sd0,     18'sd173,   18'sd404,   18'sd743,   18'sd1242,
    18'sd1950,  18'sd2915,  18'sd4176,  18'sd5763,  18'sd7694,
    18'sd9972,  18'sd12588, 18'sd15513, 18'sd18705, 18'sd22107,
    18'sd25648, 18'sd29247, 18'sd32815, 18'sd36258, 18'sd39481,
    18'sd42392, 18'sd44904, 18'sd46944, 18'sd48447, 18'sd49369,
    18'sd49679, 18'sd49369, 18'sd48447, 18'sd46944, 18'sd44904,
    18'sd42392, 18'sd39481, 18'sd36258, 18'sd32815, 18'sd29247,
    18'sd25648, 18'sd22107, 18'sd18705, 18'sd15513, 18'sd12588,
    18'sd9972,  18'sd7694,  18'sd5763,  18'sd4176,  18'sd2915,
    18'sd1950,  18'sd1242,  18'sd743,   18'sd404,   18'sd173,
    18'sd0
  };

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* design/dcfir_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcfir_mac (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire dcfir_pkg::mac_ctrl_t                      ctrl_i,
  input  wire logic signed [dcfir_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic signed [dcfir_pkg::COEF_WIDTH-1:0]   coef_i,
  output logic signed [dcfir_pkg::SAMPLE_WIDTH-1:0]      result_o
);
  import dcfir_pkg::*;

  logic signed [PROD_WIDTH-1:0] prod_q;
  logic signed [ACC_WIDTH-1:0]  acc_q;
  logic signed [ACC_WIDTH-1:0]  rounded;
  logic signed [QUOT_WIDTH-1:0] quot;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= sample_i * coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + {{(ACC_WIDTH - PROD_WIDTH){prod_q[PROD_WIDTH-1]}}, prod_q};
    end
  end

  // round half up, floor shift, then saturate to the 16-bit sample range
  always_comb begin
    rounded = acc_q + ROUND_BIAS;
    quot    = rounded[ACC_WIDTH-1:FRAC_BITS];
    if (quot > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (quot < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result_o = quot[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/dual_channel_fir_lowpass.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dual-channel 51-tap low-pass FIR. Each transfer carries a red and an infrared
// AC sample plus two DC levels; the AC samples are written into one shared
// 51-entry history memory (red and infrared side by side) and each channel is
// filtered with the same symmetric coefficient set, result = sum(c*x) rounded
// half up, shifted right by 20 and saturated to 16 bits. The DC levels are
// copied through. One item is worked at a time: the sequencer reads one
// history entry per cycle and feeds one multiply-accumulate per channel; each
// product is registered and then added into the accumulator. Once the pipeline
// has drained and the output register is free, the result is loaded there, and
// the input is ready again in the same cycle as the result turns valid. A finished result
// sits in the output register while the next item is already accepted; if that
// register is still held by the sink when the next result is done, the filter
// waits in drain and the input stays stalled. The history reads as zero after
// reset through per-entry valid bits, so no clearing pass is needed.
module dual_channel_fir_lowpass (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // ac_red, ac_infrared, dc_red, dc_infrared
  input  wire logic [dcfir_pkg::TDATA_WIDTH-1:0] s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // filtered_red, filtered_infrared, dc_red_out, dc_infrared_out
  output logic [dcfir_pkg::TDATA_WIDTH-1:0]      m_axis_tdata_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i
);
  import dcfir_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [ADDR_WIDTH-1:0]   newest_q, newest_d;
  logic [ADDR_WIDTH-1:0]   rd_addr_q, rd_addr_d;
  logic [ADDR_WIDTH-1:0]   tap_q, tap_d;
  logic [TAP_COUNT-1:0]    valid_q;
  logic                    s1_q, s1_d;
  logic                    s2_q;
  logic [2*SAMPLE_WIDTH-1:0] hist_mem [TAP_COUNT];
  logic [2*SAMPLE_WIDTH-1:0] rd_data_q;
  logic                    rd_vld_q;
  logic signed [COEF_WIDTH-1:0] coef_q;
  logic [SAMPLE_WIDTH-1:0] dc_red_q, dc_ir_q;
  logic [TDATA_WIDTH-1:0]  out_data_q;
  logic                    out_valid_q;

  logic s_xfer, out_free, out_load;
  mac_ctrl_t mac_ctrl;
  logic signed [SAMPLE_WIDTH-1:0] red_sample, ir_sample;
  logic signed [SAMPLE_WIDTH-1:0] red_result, ir_result;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == ST_DRAIN) && !s1_q && !s2_q && out_free;

  always_comb begin
    state_d   = state_q;
    newest_d  = newest_q;
    rd_addr_d = rd_addr_q;
    tap_d     = tap_q;
    s1_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          newest_d  = (newest_q == LAST_TAP) ? '0 : newest_q + 1'b1;
          rd_addr_d = newest_d;
          tap_d     = '0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        s1_d      = 1'b1;
        rd_addr_d = (rd_addr_q == '0) ? LAST_TAP : rd_addr_q - 1'b1;
        if (tap_q == LAST_TAP) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      newest_q    <= '0;
      rd_addr_q   <= '0;
      tap_q       <= '0;
      valid_q     <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      newest_q  <= newest_d;
      rd_addr_q <= rd_addr_d;
      tap_q     <= tap_d;
      s1_q      <= s1_d;
      s2_q      <= s1_q;
      if (s_xfer) begin
        valid_q[newest_d] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // history memory: write on input transfer, one read per cycle while running
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      hist_mem[newest_d] <= s_axis_tdata_i[2*SAMPLE_WIDTH-1:0];
    end
    rd_data_q <= hist_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[rd_addr_q];
    coef_q   <= COEF_TABLE[tap_q];
    if (s_xfer) begin
      dc_red_q <= s_axis_tdata_i[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
      dc_ir_q  <= s_axis_tdata_i[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];
    end
    if (out_load) begin
      out_data_q <= {dc_ir_q, dc_red_q, ir_result, red_result};
    end
  end

  // entries never written since reset read as zero
  assign red_sample = rd_vld_q ? rd_data_q[SAMPLE_WIDTH-1:0] : '0;
  assign ir_sample  = rd_vld_q ? rd_data_q[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;

  assign mac_ctrl.clear  = s_xfer;
  assign mac_ctrl.mul_en = s1_q;
  assign mac_ctrl.acc_en = s2_q;

  dcfir_mac u_mac_red (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (red_sample),
    .coef_i   (coef_q),
    .result_o (red_result)
  );

  dcfir_mac u_mac_ir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (ir_sample),
    .coef_i   (coef_q),
    .result_o (ir_result)
  );

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tvalid_o = out_valid_q;

endmodule

`default_nettype wire

/* design/dcfir_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcfir_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic [dcfir_pkg::TDATA_WIDTH-1:0] s_axis_tdata_i,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [dcfir_pkg::TDATA_WIDTH-1:0] m_axis_tdata_o,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i
);

  // one item in flight: no second input transfer right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while an item is still being filtered");

  // a new result appears only as the filter returns to waiting for input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result raised while the filter is still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output valid dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("output data changed while stalled");

endmodule

bind dual_channel_fir_lowpass dcfir_checker u_dcfir_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
